// ===== rtl/fkc_pkg.sv =====
// fkc_pkg: shared constants, kernel weight table and types of the 5x5 fixed-kernel filter
package fkc_pkg;

   // default geometry limits
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   // window and datapath widths
   localparam int TAPS      = 5;
   localparam int PIX_W     = 8;
   localparam int WGT_W     = 5;
   localparam int PROD_W    = 13;
   localparam int SUM_W     = 15;
   localparam int TAP_IDX_W = $clog2(TAPS*TAPS);

   // register file layout
   localparam int KS_W       = 2;
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_SEL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic [KS_W-1:0] KS_RESET = 2'd0;
   localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
   localparam logic [FH_W-1:0] FH_RESET = 13'd4096;

   // input word kinds
   localparam logic REQ_DRAIN = 1'b1;

   typedef logic signed [WGT_W-1:0] weight_type;
   typedef logic [TAPS-1:0]         tap_mask_type;

   // which window rows and columns fall inside the frame
   typedef struct packed {
      tap_mask_type rows;
      tap_mask_type cols;
   } win_mask_type;

   // control of one window row
   typedef struct packed {
      logic         shift;
      logic         calc;
      logic         sum_en;
      logic         keep_row;
      tap_mask_type keep_cols;
   } row_ctl_type;

   // weights, row-major, top row first, left column first
   localparam weight_type KERNEL_TAB [4][TAPS*TAPS] = '{
      // texture, horizontal
      '{ 5'sd1,  5'sd2,  5'sd0, -5'sd2,  -5'sd1,
         5'sd4,  5'sd8,  5'sd0, -5'sd8,  -5'sd4,
         5'sd6,  5'sd12, 5'sd0, -5'sd12, -5'sd6,
         5'sd4,  5'sd8,  5'sd0, -5'sd8,  -5'sd4,
         5'sd1,  5'sd2,  5'sd0, -5'sd2,  -5'sd1 },
      // texture, vertical
      '{ 5'sd1,  5'sd4,  5'sd6,   5'sd4,  5'sd1,
         5'sd2,  5'sd8,  5'sd12,  5'sd8,  5'sd2,
         5'sd0,  5'sd0,  5'sd0,   5'sd0,  5'sd0,
        -5'sd2, -5'sd8, -5'sd12, -5'sd8, -5'sd2,
        -5'sd1, -5'sd4, -5'sd6,  -5'sd4, -5'sd1 },
      // luminance, horizontal
      '{ 5'sd1,  5'sd1,  5'sd0,  5'sd1,  5'sd1,
         5'sd1,  5'sd2,  5'sd0,  5'sd2,  5'sd1,
         5'sd1,  5'sd2,  5'sd0,  5'sd2,  5'sd1,
         5'sd1,  5'sd2,  5'sd0,  5'sd2,  5'sd1,
         5'sd1,  5'sd1,  5'sd0,  5'sd1,  5'sd1 },
      // luminance, vertical
      '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,
         5'sd1,  5'sd2,  5'sd2,  5'sd2,  5'sd1,
         5'sd0,  5'sd0,  5'sd0,  5'sd0,  5'sd0,
         5'sd1,  5'sd2,  5'sd2,  5'sd2,  5'sd1,
         5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1 }
   };

   // weight of one window position for the selected kernel
   function automatic weight_type kernel_weight(logic [KS_W-1:0] sel, int unsigned row,
                                                int unsigned col);
      return KERNEL_TAB[sel][TAP_IDX_W'(row*TAPS + col)];
   endfunction

endpackage

// ===== rtl/fkc_line_buf.sv =====
// fkc_line_buf: four packed line stores, one read and one write per cycle, with write bypass
module fkc_line_buf import fkc_pkg::*; #(
   parameter  int DEPTH = DEF_MAX_WIDTH,
   localparam int AW    = $clog2(DEPTH),
   localparam int DW    = (TAPS-1)*PIX_W
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] q_ff;
   logic [DW-1:0] byp_data_ff;
   logic          byp_ff;

   // storage write and registered read; a same-address write wins over the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff        <= mem[rd_addr];
         byp_data_ff <= wr_data;
         byp_ff      <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : q_ff;

endmodule

// ===== rtl/fkc_cell.sv =====
// fkc_cell: one window position, holds a pixel, passes it left, forms its weighted product
module fkc_cell import fkc_pkg::*; (
   input  logic                     clock,
   input  logic                     shift,
   input  logic                     calc,
   input  logic                     keep,
   input  weight_type               weight,
   input  logic [PIX_W-1:0]         pix_in,
   output logic [PIX_W-1:0]         pix_out,
   output logic signed [PROD_W-1:0] product
);

   logic [PIX_W-1:0]            pix_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [PIX_W+WGT_W:0] pix_ext;
   logic signed [PIX_W+WGT_W:0] wgt_ext;
   logic signed [PIX_W+WGT_W:0] full;

   // small constant-range product, zero outside the frame
   assign pix_ext = $signed({{(WGT_W+1){1'b0}}, pix_ff});
   assign wgt_ext = (PIX_W+WGT_W+1)'(weight);
   assign full    = pix_ext * wgt_ext;
   assign prod_in = keep ? $signed(full[PROD_W-1:0]) : '0;

   always_ff @(posedge clock) begin
      if (shift) begin
         pix_ff <= pix_in;
      end
      if (calc) begin
         prod_ff <= prod_in;
      end
   end

   assign pix_out = pix_ff;
   assign product = prod_ff;

endmodule

// ===== rtl/fkc_row.sv =====
// fkc_row: one window row of chained cells and its registered row sum
module fkc_row import fkc_pkg::*; (
   input  logic                    clock,
   input  row_ctl_type             ctl,
   input  weight_type              weights [TAPS],
   input  logic [PIX_W-1:0]        pix_in,
   output logic signed [SUM_W-1:0] row_sum
);

   logic [PIX_W-1:0]         chain [1:TAPS];
   logic signed [PROD_W-1:0] prod  [TAPS];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;

   assign chain[TAPS] = pix_in;

   // newest column enters at the right and moves left one cell per word
   for (genvar j = 0; j < TAPS; j++) begin : g_cell
      if (j == 0) begin : g_end
         fkc_cell u_cell (
            .clock   (clock),
            .shift   (ctl.shift),
            .calc    (ctl.calc),
            .keep    (ctl.keep_row & ctl.keep_cols[j]),
            .weight  (weights[j]),
            .pix_in  (chain[j+1]),
            .pix_out (),
            .product (prod[j])
         );
      end else begin : g_mid
         fkc_cell u_cell (
            .clock   (clock),
            .shift   (ctl.shift),
            .calc    (ctl.calc),
            .keep    (ctl.keep_row & ctl.keep_cols[j]),
            .weight  (weights[j]),
            .pix_in  (chain[j+1]),
            .pix_out (chain[j]),
            .product (prod[j])
         );
      end
   end

   // row sum of the five products
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < TAPS; j++) begin
         sum_in = sum_in + SUM_W'(prod[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_en) begin
         sum_ff <= sum_in;
      end
   end

   assign row_sum = sum_ff;

endmodule

// ===== rtl/fixed_kernel_5x5_conv.sv =====
// fixed_kernel_5x5_conv: top level of the streaming 5x5 fixed-kernel filter
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_type, req_pixel
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_filtered_value, rsp_frame_end
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// One word per cycle sustained while rsp does not stall; the line store does one read and one write per word.
// The result of the word that completes a window passes stages a, b, c and d into the output register.
// A frame of W x H pixels takes W*H + 2*W + 2 words; the last 2*W + 2 only drain, whatever their type.
// Reset clears counters, valid flags and registers only; the line store needs no clearing.
// When rsp stalls, empty stages still fill, then req_ready drops.
module fixed_kernel_5x5_conv import fkc_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_type,
   input  logic [PIX_W-1:0]        req_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [SUM_W-1:0] rsp_filtered_value,
   output logic                    rsp_frame_end,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WD_W   = $clog2(MAX_WIDTH + 1);
   localparam int CW2    = WD_W + 1;
   localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
   localparam int OROW_W = $clog2(MAX_HEIGHT);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 4);
   localparam int LAG_W  = $clog2(2*MAX_WIDTH + 3);
   localparam int DW     = (TAPS-1)*PIX_W;

   // configuration registers
   logic [KS_W-1:0] kernel_sel_ff;
   logic [FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0] frame_height_ff;

   // stream position state
   logic [COL_W-1:0]  in_col_ff,  in_col_in;
   logic [ROW_W-1:0]  in_row_ff,  in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [OROW_W-1:0] out_row_ff, out_row_in;
   logic [LAG_W-1:0]  pre_cnt_ff, pre_cnt_in;
   logic              started_ff, started_in;
   logic [WD_W-1:0]   cur_w_ff,   cur_w_in;
   logic [HD_W-1:0]   cur_h_ff,   cur_h_in;

   // front-end decode
   logic             first;
   logic [WD_W-1:0]  w_cfg, w_eff;
   logic [HD_W-1:0]  h_cfg, h_eff;
   logic [LAG_W-1:0] lag;
   logic             in_frame, col_wrap, out_wrap;
   logic             res, last;
   logic [PIX_W-1:0] x_val;
   win_mask_type     mask;

   // pipeline stages
   logic             a_v_ff, b_v_ff, c_v_ff, d_v_ff, out_v_ff;
   logic [PIX_W-1:0] a_x_ff;
   logic [COL_W-1:0] a_col_ff;
   logic             a_res_ff, a_last_ff, b_res_ff, b_last_ff, c_last_ff, d_last_ff;
   logic             out_last_ff;
   win_mask_type     a_mask_ff, b_mask_ff;
   logic signed [SUM_W-1:0] out_sum_ff;
   logic signed [SUM_W-1:0] total;

   logic accept, a_move, a_free, b_move, b_free, c_move, c_free, d_move, d_free, out_load;

   // window datapath
   logic [DW-1:0]           lb_rd, lb_wr;
   logic [PIX_W-1:0]        col_pix [TAPS];
   weight_type              row_wgt [TAPS][TAPS];
   logic signed [SUM_W-1:0] row_sum [TAPS];
   row_ctl_type             row_ctl [TAPS];

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_sel_ff   <= KS_RESET;
         frame_width_ff  <= FW_RESET;
         frame_height_ff <= FH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KERNEL_SEL:   kernel_sel_ff   <= csr_data[KS_W-1:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the programmed geometry to the supported range
   always_comb begin
      if (frame_width_ff == '0) begin
         w_cfg = WD_W'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         w_cfg = WD_W'(MAX_WIDTH);
      end else begin
         w_cfg = WD_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         h_cfg = HD_W'(1);
      end else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) begin
         h_cfg = HD_W'(MAX_HEIGHT);
      end else begin
         h_cfg = HD_W'(frame_height_ff);
      end
   end

   // geometry latched on the first word of a frame
   assign first    = (in_row_ff == '0) && (in_col_ff == '0);
   assign w_eff    = first ? w_cfg : cur_w_ff;
   assign h_eff    = first ? h_cfg : cur_h_ff;
   assign lag      = LAG_W'({w_eff, 1'b0}) + LAG_W'(2);
   assign in_frame = in_row_ff < ROW_W'(h_eff);
   assign col_wrap = (WD_W'(in_col_ff) + WD_W'(1)) == w_eff;
   assign out_wrap = (CW2'(out_col_ff) + CW2'(1)) == CW2'(w_eff);
   assign res      = started_ff || (pre_cnt_ff == lag);
   assign last     = res && out_wrap
                     && ((ROW_W'(out_row_ff) + ROW_W'(1)) == ROW_W'(h_eff));
   assign x_val    = (in_frame && (req_type != REQ_DRAIN)) ? req_pixel : '0;

   // which neighbors of the output pixel lie inside the frame
   always_comb begin
      mask.rows[0] = out_row_ff >= OROW_W'(2);
      mask.rows[1] = out_row_ff != '0;
      mask.rows[2] = 1'b1;
      mask.rows[3] = (ROW_W'(out_row_ff) + ROW_W'(1)) < ROW_W'(h_eff);
      mask.rows[4] = (ROW_W'(out_row_ff) + ROW_W'(2)) < ROW_W'(h_eff);
      mask.cols[0] = out_col_ff >= COL_W'(2);
      mask.cols[1] = out_col_ff != '0;
      mask.cols[2] = 1'b1;
      mask.cols[3] = (CW2'(out_col_ff) + CW2'(1)) < CW2'(w_eff);
      mask.cols[4] = (CW2'(out_col_ff) + CW2'(2)) < CW2'(w_eff);
   end

   // position counters, advanced once per accepted word
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pre_cnt_in = pre_cnt_ff;
      started_in = started_ff;
      cur_w_in   = cur_w_ff;
      cur_h_in   = cur_h_ff;
      if (accept) begin
         if (first) begin
            cur_w_in = w_cfg;
            cur_h_in = h_cfg;
         end
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            pre_cnt_in = '0;
            started_in = 1'b0;
         end else begin
            if (col_wrap) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            if (res) begin
               started_in = 1'b1;
               if (out_wrap) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + OROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end else begin
               pre_cnt_in = pre_cnt_ff + LAG_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pre_cnt_ff <= '0;
         started_ff <= 1'b0;
         cur_w_ff   <= '0;
         cur_h_ff   <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pre_cnt_ff <= pre_cnt_in;
         started_ff <= started_in;
         cur_w_ff   <= cur_w_in;
         cur_h_ff   <= cur_h_in;
      end
   end

   // stage flow; words without a result leave after shifting the window
   assign out_load  = !out_v_ff || rsp_ready;
   assign d_move    = d_v_ff && out_load;
   assign d_free    = !d_v_ff || out_load;
   assign c_move    = c_v_ff && d_free;
   assign c_free    = !c_v_ff || d_free;
   assign b_move    = b_v_ff && (!b_res_ff || c_free);
   assign b_free    = !b_v_ff || b_move;
   assign a_move    = a_v_ff && b_free;
   assign a_free    = !a_v_ff || a_move;
   assign req_ready = a_free;
   assign accept    = req_valid && req_ready;

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
         c_v_ff   <= 1'b0;
         d_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         a_v_ff   <= accept || (a_v_ff && !a_move);
         b_v_ff   <= a_move || (b_v_ff && !b_move);
         c_v_ff   <= (b_move && b_res_ff) || (c_v_ff && !c_move);
         d_v_ff   <= c_move || (d_v_ff && !d_move);
         out_v_ff <= d_move || (out_v_ff && !rsp_ready);
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         a_x_ff    <= x_val;
         a_col_ff  <= in_col_ff;
         a_res_ff  <= res;
         a_last_ff <= last;
         a_mask_ff <= mask;
      end
      if (a_move) begin
         b_res_ff  <= a_res_ff;
         b_last_ff <= a_last_ff;
         b_mask_ff <= a_mask_ff;
      end
      if (b_move && b_res_ff) begin
         c_last_ff <= b_last_ff;
      end
      if (c_move) begin
         d_last_ff <= c_last_ff;
      end
      if (d_move) begin
         out_sum_ff  <= total;
         out_last_ff <= d_last_ff;
      end
   end

   // line stores: read on accept, rotate the column on write
   fkc_line_buf #(
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .wr_en   (a_move),
      .wr_addr (a_col_ff),
      .wr_data (lb_wr),
      .rd_data (lb_rd)
   );

   assign lb_wr = {lb_rd[DW-PIX_W-1:0], a_x_ff};

   // column entering the window, oldest row on top
   always_comb begin
      col_pix[TAPS-1] = a_x_ff;
      for (int k = 0; k < TAPS-1; k++) begin
         col_pix[TAPS-2-k] = lb_rd[k*PIX_W +: PIX_W];
      end
   end

   // weights of the selected kernel
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         for (int j = 0; j < TAPS; j++) begin
            row_wgt[i][j] = kernel_weight(kernel_sel_ff, i, j);
         end
      end
   end

   // window rows
   for (genvar i = 0; i < TAPS; i++) begin : g_row
      assign row_ctl[i].shift     = a_move;
      assign row_ctl[i].calc      = b_move && b_res_ff;
      assign row_ctl[i].sum_en    = c_move;
      assign row_ctl[i].keep_row  = b_mask_ff.rows[i];
      assign row_ctl[i].keep_cols = b_mask_ff.cols;

      fkc_row u_row (
         .clock   (clock),
         .ctl     (row_ctl[i]),
         .weights (row_wgt[i]),
         .pix_in  (col_pix[i]),
         .row_sum (row_sum[i])
      );
   end

   // final sum of the five row sums
   always_comb begin
      total = '0;
      for (int i = 0; i < TAPS; i++) begin
         total = total + row_sum[i];
      end
   end

   assign rsp_valid          = out_v_ff;
   assign rsp_filtered_value = out_sum_ff;
   assign rsp_frame_end      = out_last_ff;

endmodule

// ===== rtl/fkc_checker.sv =====
// fkc_checker: port-level checks of the 5x5 filter, bound to the top level
module fkc_checker import fkc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [SUM_W-1:0] rsp_filtered_value,
   input logic                    rsp_frame_end
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered_value)
                                  && $stable(rsp_frame_end))
      else $error("result word changed while stalled");

   // the weighted sum never leaves the kernel range
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_filtered_value >= -15'sd12240)
                    && (rsp_filtered_value <= 15'sd12240))
      else $error("filtered value out of range");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   // input back-pressure only comes from a stalled output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output stall");

endmodule

bind fixed_kernel_5x5_conv fkc_checker u_fkc_checker (.*);

// ===== tb/sv/tb_fixed_kernel_5x5_conv.sv =====
// testbench for the streaming 5x5 fixed-kernel filter: directed table, random frames, checker
`timescale 1ns / 1ps

module tb_fixed_kernel_5x5_conv import fkc_pkg::*; ();

   // local codes
   localparam logic                 REQ_DATA   = ~REQ_DRAIN;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned          HIST_LEN   = 4 * DEF_MAX_WIDTH + 8;
   localparam int unsigned          RANDOM_WORDS = 1650;
   localparam int unsigned          SETTLE_CYCLES = 16;

   typedef enum logic [KS_W-1:0] {KS_TEX_H, KS_TEX_V, KS_LUM_H, KS_LUM_V} kernel_sel_type;
   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum logic [1:0] {PAT_NOISE, PAT_BINARY, PAT_COL_STEP, PAT_ROW_STEP} pattern_type;
   typedef enum logic {ROW_CSR, ROW_WORD} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} check_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] value;
      logic                    last;
   } sum_item_type;

   typedef struct packed {
      row_kind_type            kind;
      logic                    wtype;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]   data;
      check_type               check;
      logic signed [SUM_W-1:0] sum;
      logic                    last;
   } plan_row_type;

   // weights per kernel, row-major, top-left first
   localparam int TAP_WEIGHTS [4][25] = '{
      '{ 1,  2,   0,  -2, -1,   4,  8,  0, -8, -4,   6, 12, 0, -12, -6,
         4,  8,   0,  -8, -4,   1,  2,  0, -2, -1 },
      '{ 1,  4,   6,   4,  1,   2,  8, 12,  8,  2,   0,  0, 0,   0,  0,
        -2, -8, -12,  -8, -2,  -1, -4, -6, -4, -1 },
      '{ 1,  1,   0,   1,  1,   1,  2,  0,  2,  1,   1,  2, 0,   2,  1,
         1,  2,   0,   2,  1,   1,  1,  0,  1,  1 },
      '{ 1,  1,   1,   1,  1,   1,  2,  2,  2,  1,   0,  0, 0,   0,  0,
         1,  2,   2,   2,  1,   1,  1,  1,  1,  1 }
   };

   // directed table: 1x1 frame, then a 3x2 frame with a kernel change in its tail
   localparam int N_PLAN = 27;
   localparam plan_row_type PLAN [N_PLAN] = '{
      '{ROW_CSR,  REQ_DATA,  CSR_FRAME_WIDTH,  13'd0,             CHK_NONE,  15'sd0, 1'b0},
      '{ROW_CSR,  REQ_DATA,  CSR_FRAME_HEIGHT, 13'd0,             CHK_NONE,  15'sd0, 1'b0},
      '{ROW_CSR,  REQ_DATA,  CSR_KERNEL_SEL,   {11'd0, KS_LUM_V}, CHK_NONE,  15'sd0, 1'b0},
      '{ROW_WORD, REQ_DATA,  '0,               13'd255,           CHK_NONE,  15'sd0, 1'b0},
      '{ROW_WORD, REQ_DATA,  '0,               13'd255,           CHK_NONE,  15'sd0, 1'b0},
      '{ROW_WORD, REQ_DRAIN, '0,               13'd255,           CHK_NONE,  15'sd0, 1'b0},
      '{ROW_WORD, REQ_DATA,  '0,               13'd0,             CHK_NONE,  15'sd0, 1'b0},
      '{ROW_WORD, REQ_DRAIN, '0,               13'd0,             CHK_GIVEN, 15'sd0, 1'b1},
      '{ROW_CSR,  REQ_DATA,  CSR_UNUSED,       13'd8191,          CHK_NONE,  15'sd0, 1'b0},
      '{ROW_CSR,  REQ_DATA,  CSR_FRAME_WIDTH,  13'd3,             CHK_NONE,  15'sd0, 1'b0},
      '{ROW_CSR,  REQ_DATA,  CSR_FRAME_HEIGHT, 13'd2,             CHK_NONE,  15'sd0, 1'b0},
      '{ROW_CSR,  REQ_DATA,  CSR_KERNEL_SEL,   {11'd0, KS_TEX_V}, CHK_NONE,  15'sd0, 1'b0},
      '{ROW_WORD, REQ_DATA,  '0,               13'd255,           CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_WORD, REQ_DATA,  '0,               13'd0,             CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_WORD, REQ_DATA,  '0,               13'd255,           CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_WORD, REQ_DRAIN, '0,               13'd200,           CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_WORD, REQ_DATA,  '0,               13'd255,           CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_WORD, REQ_DATA,  '0,               13'd1,             CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_WORD, REQ_DRAIN, '0,               13'd0,             CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_WORD, REQ_DRAIN, '0,               13'd0,             CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_WORD, REQ_DRAIN, '0,               13'd0,             CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_WORD, REQ_DATA,  '0,               13'd77,            CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_WORD, REQ_DRAIN, '0,               13'd0,             CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_CSR,  REQ_DATA,  CSR_KERNEL_SEL,   {11'd0, KS_TEX_H}, CHK_NONE,  15'sd0, 1'b0},
      '{ROW_WORD, REQ_DRAIN, '0,               13'd0,             CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_WORD, REQ_DRAIN, '0,               13'd0,             CHK_MODEL, 15'sd0, 1'b0},
      '{ROW_WORD, REQ_DRAIN, '0,               13'd0,             CHK_MODEL, 15'sd0, 1'b0}
   };

   // dut ports
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_type = 1'b0;
   logic [PIX_W-1:0]        req_pixel = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [SUM_W-1:0] rsp_filtered_value;
   logic                    rsp_frame_end;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   fixed_kernel_5x5_conv dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_pixel          (req_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_frame_end      (rsp_frame_end),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // clock, 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // filter state mirrored by the testbench
   logic [PIX_W-1:0] pix_hist [HIST_LEN];
   int unsigned      kern_sel = 0;
   int unsigned      reg_w = 1024;
   int unsigned      reg_h = 4096;
   int unsigned      cur_w = 1024;
   int unsigned      cur_h = 4096;
   int unsigned      in_col = 0;
   int unsigned      in_row = 0;
   int unsigned      out_col = 0;
   int unsigned      out_row = 0;

   sum_item_type pending_sums [$];
   sum_item_type head_sum;
   int unsigned  fail_count = 0;
   int unsigned  words_sent = 0;
   int unsigned  gap_pct = 0;
   int unsigned  stall_pct = 0;

   function automatic int unsigned clip_dim(input int unsigned v, input int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   // one neighbour of the window, zero outside the frame
   function automatic int window_tap(input int r, input int c);
      if (r < 0 || c < 0 || r >= int'(cur_h) || c >= int'(cur_w)) return 0;
      return int'(pix_hist[(r * cur_w + c) % HIST_LEN]);
   endfunction

   function automatic void note_csr(input logic [CSR_IDX_W-1:0] idx,
                                    input logic [CSR_DATA_W-1:0] data);
      unique case (idx)
         CSR_KERNEL_SEL:   kern_sel = data[KS_W-1:0];
         CSR_FRAME_WIDTH:  reg_w = data[FW_W-1:0];
         CSR_FRAME_HEIGHT: reg_h = data[FH_W-1:0];
         default: ;
      endcase
   endfunction

   // advance the filter by one word, give the weighted sum it releases if any
   task automatic filter_step(input logic wtype, input logic [PIX_W-1:0] pix,
                              output bit has, output sum_item_type res);
      int unsigned pos;
      int          acc;
      bit          is_last;
      acc = 0;
      has = 1'b0;
      res = '0;
      // geometry is latched on the first word of a frame
      if (in_row == 0 && in_col == 0) begin
         cur_w = clip_dim(reg_w, DEF_MAX_WIDTH);
         cur_h = clip_dim(reg_h, DEF_MAX_HEIGHT);
      end
      pos = in_row * cur_w + in_col;
      pix_hist[pos % HIST_LEN] = (pos < cur_w * cur_h && wtype != REQ_DRAIN) ? pix : '0;
      in_col++;
      if (in_col >= cur_w) begin
         in_col = 0;
         in_row++;
      end
      if (pos >= 2 * cur_w + 2) begin
         for (int dr = -2; dr <= 2; dr++) begin
            for (int dc = -2; dc <= 2; dc++) begin
               acc += TAP_WEIGHTS[kern_sel][(dr + 2) * 5 + dc + 2]
                      * window_tap(int'(out_row) + dr, int'(out_col) + dc);
            end
         end
         is_last = (out_row + 1 >= cur_h) && (out_col + 1 >= cur_w);
         res.value = acc[SUM_W-1:0];
         res.last = is_last;
         has = 1'b1;
         if (is_last) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
         end else begin
            out_col++;
            if (out_col >= cur_w) begin
               out_col = 0;
               out_row++;
            end
         end
      end
   endtask

   task automatic set_idling(input idle_mode_type mode);
      unique case (mode)
         IDLE_NONE: begin
            gap_pct = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            gap_pct = 78;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            gap_pct = 0;
            stall_pct = 78;
         end
         default: begin
            gap_pct = 15;
            stall_pct = 15;
         end
      endcase
   endtask

   // send one word and record the sum it should release
   task automatic send_word(input logic wtype, input logic [PIX_W-1:0] pix,
                            input check_type chk,
                            input logic signed [SUM_W-1:0] given_sum, input logic given_last);
      sum_item_type next_sum;
      bit           has;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= wtype;
      req_pixel <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      filter_step(wtype, pix, has, next_sum);
      if (chk == CHK_GIVEN) begin
         next_sum.value = given_sum;
         next_sum.last = given_last;
         pending_sums.push_back(next_sum);
      end else if (chk == CHK_MODEL && has) begin
         pending_sums.push_back(next_sum);
      end
      words_sent++;
   endtask

   // stop sending, let every pending sum arrive and the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      note_csr(idx, data);
      @(posedge clock);
   endtask

   // mostly small frame sizes, sometimes zero or somewhat wider
   function automatic int unsigned pick_dim();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0) return 0;
      if (r < 3) return $urandom_range(13, 24);
      return $urandom_range(1, 12);
   endfunction

   // new register values, junk in the bits above each field
   task automatic retune(input bit all_regs);
      if (all_regs || $urandom_range(0, 3) != 0)
         write_csr(CSR_KERNEL_SEL, {11'($urandom()), 2'($urandom())});
      if (all_regs || $urandom_range(0, 1) != 0)
         write_csr(CSR_FRAME_WIDTH, {2'($urandom()), 11'(pick_dim())});
      if (all_regs || $urandom_range(0, 1) != 0)
         write_csr(CSR_FRAME_HEIGHT, 13'(pick_dim()));
      if ($urandom_range(0, 15) == 0)
         write_csr(CSR_UNUSED, 13'($urandom()));
   endtask

   // one whole frame of pixels and drain words, maybe with a register change inside
   task automatic run_frame();
      int unsigned      w, h, area, total, brk, step_at, row, col;
      pattern_type      pat;
      logic [PIX_W-1:0] hi, lo, pix;
      logic             wtype;
      w = clip_dim(reg_w, DEF_MAX_WIDTH);
      h = clip_dim(reg_h, DEF_MAX_HEIGHT);
      area = w * h;
      total = area + 2 * w + 2;
      brk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, total - 1) : 0;
      pat = pattern_type'($urandom_range(0, 3));
      hi = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      lo = ~hi;
      step_at = (pat == PAT_ROW_STEP) ? $urandom_range(0, h) : $urandom_range(0, w);
      for (int unsigned n = 0; n < total; n++) begin
         if (brk != 0 && n == brk) begin
            settle();
            retune(1'b0);
         end
         row = n / w;
         col = n % w;
         unique case (pat)
            PAT_NOISE:    pix = 8'($urandom_range(0, 255));
            PAT_BINARY:   pix = $urandom_range(0, 1) ? hi : lo;
            PAT_COL_STEP: pix = (col < step_at) ? hi : lo;
            default:      pix = (row < step_at) ? hi : lo;
         endcase
         wtype = REQ_DATA;
         if (n >= area) begin
            // tail: mostly drain words, some stray pixels that must be ignored
            wtype = ($urandom_range(0, 3) == 0) ? REQ_DATA : REQ_DRAIN;
            pix = 8'($urandom_range(0, 255));
         end else if ($urandom_range(0, 23) == 0) begin
            wtype = REQ_DRAIN;
         end
         send_word(wtype, pix, CHK_MODEL, '0, 1'b0);
      end
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_sums.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result: filtered_value %0d frame_end %0b",
                           rsp_filtered_value, rsp_frame_end);
               fail_count++;
            end else begin
               head_sum = pending_sums.pop_front();
               if (rsp_filtered_value !== head_sum.value || rsp_frame_end !== head_sum.last) begin
                  if (fail_count < 10)
                     $display("mismatch: filtered_value exp %0d got %0d, frame_end exp %0b got %0b",
                              head_sum.value, rsp_filtered_value, head_sum.last, rsp_frame_end);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // stimulus
   initial begin
      int unsigned base;
      foreach (pix_hist[i]) pix_hist[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      set_idling(IDLE_BOTH);
      for (int i = 0; i < N_PLAN; i++) begin
         if (PLAN[i].kind == ROW_CSR) begin
            settle();
            write_csr(PLAN[i].idx, PLAN[i].data);
         end else begin
            send_word(PLAN[i].wtype, PLAN[i].data[PIX_W-1:0], PLAN[i].check,
                      PLAN[i].sum, PLAN[i].last);
         end
      end

      // small random frames through all idling modes
      settle();
      retune(1'b1);
      base = words_sent;
      while (words_sent - base < RANDOM_WORDS) begin
         set_idling(idle_mode_type'((words_sent - base) * 4 / RANDOM_WORDS));
         run_frame();
         if ($urandom_range(0, 1) != 0) begin
            settle();
            retune(1'b0);
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
